// ===== rtl/ebse_pkg.sv =====
package ebse_pkg;

  localparam int NUM_ENCODERS = 4;
  localparam int NUM_BUTTONS  = 7;
  localparam int NUM_LANES    = NUM_ENCODERS + NUM_BUTTONS;
  localparam int LANE_W       = $clog2(NUM_LANES);

  localparam int SCAN_W = 16;
  localparam int BIT_W  = $clog2(SCAN_W);
  localparam int SPD_W  = 4;
  localparam int CNT_W  = 8;
  localparam int KIND_W = 2;
  localparam int SRC_W  = 3;
  localparam int AMT_W  = 5;
  localparam int OUT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Scan word bit positions (active low) of phase A / phase B and buttons
  localparam logic [BIT_W-1:0] ENC_A_BIT [4] = '{4'd11, 4'd0, 4'd1, 4'd2};
  localparam logic [BIT_W-1:0] ENC_B_BIT [4] = '{4'd13, 4'd12, 4'd7, 4'd6};
  localparam logic [BIT_W-1:0] BTN_BIT   [7] =
    '{4'd8, 4'd15, 4'd9, 4'd14, 4'd10, 4'd4, 4'd3};

  // Two-sample history {prev B, prev A, B, A}: a detent into both-low
  localparam logic [3:0] QUAD_UP_STEP = 4'b0111;
  localparam logic [3:0] QUAD_DN_STEP = 4'b1011;

  localparam logic [SPD_W-1:0] SPEED_RESET = 4'd1;
  localparam logic [CNT_W-1:0] HOLD_TOP    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_STEP  = 2'd0,
    REG_SPEED_LIMIT = 2'd1,
    REG_LOCKOUT     = 2'd2,
    REG_LONG_PRESS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    EVT_TURN  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_kind_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [SPD_W-1:0] speed_step;
    logic [SPD_W-1:0] speed_limit;
    logic [CNT_W-1:0] lockout_scans;
    logic [CNT_W-1:0] long_press_scans;
  } cfg_t;

  typedef struct packed {
    logic                    hit;
    evt_kind_t               kind;
    logic signed [AMT_W-1:0] amount;
  } lane_evt_t;

endpackage

// ===== rtl/ebse_enc_lane.sv =====
module ebse_enc_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               scan_en,
  input  logic               a_low,
  input  logic               b_low,
  input  logic               phase_zero,
  input  ebse_pkg::cfg_t     cfg,
  output ebse_pkg::lane_evt_t evt
);

  logic [1:0]                    hist_r, hist_nxt;
  logic [ebse_pkg::SPD_W-1:0]    sp_r, sp_nxt;
  ebse_pkg::dir_t                dir_r, dir_nxt;
  logic [ebse_pkg::CNT_W-1:0]    lock_r, lock_nxt;

  logic [3:0]                    h;
  logic                          up, dn;
  logic [ebse_pkg::SPD_W:0]      sp_wide;
  logic [ebse_pkg::AMT_W-1:0]    mag;

  always_comb begin
    h        = {hist_r, b_low, a_low};
    hist_nxt = {b_low, a_low};
    up = (h == ebse_pkg::QUAD_UP_STEP) && (dir_r != ebse_pkg::DIR_DOWN);
    dn = (h == ebse_pkg::QUAD_DN_STEP) && (dir_r != ebse_pkg::DIR_UP);
    dir_nxt  = dir_r;
    lock_nxt = lock_r;
    sp_wide  = {1'b0, sp_r};
    if (up || dn) begin
      sp_wide  = {1'b0, sp_r} + {1'b0, cfg.speed_step};
      dir_nxt  = up ? ebse_pkg::DIR_UP : ebse_pkg::DIR_DOWN;
      lock_nxt = cfg.lockout_scans;
    end else begin
      if (lock_r > 8'd1) begin
        lock_nxt = lock_r - 8'd1;
      end else if (lock_r == 8'd1) begin
        lock_nxt = '0;
        dir_nxt  = ebse_pkg::DIR_NONE;
      end
      if (sp_r > 4'd1 && phase_zero) begin
        sp_wide = {1'b0, sp_r} - 5'd1;
      end
    end
    // cap after every scan
    if (sp_wide > {1'b0, cfg.speed_limit}) begin
      sp_nxt = cfg.speed_limit;
    end else begin
      sp_nxt = sp_wide[ebse_pkg::SPD_W-1:0];
    end

    mag        = {1'b0, sp_r};
    evt.hit    = up || dn;
    evt.kind   = ebse_pkg::EVT_TURN;
    evt.amount = dn ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      sp_r   <= ebse_pkg::SPEED_RESET;
      dir_r  <= ebse_pkg::DIR_NONE;
      lock_r <= '0;
    end else if (scan_en) begin
      hist_r <= hist_nxt;
      sp_r   <= sp_nxt;
      dir_r  <= dir_nxt;
      lock_r <= lock_nxt;
    end
  end

endmodule

// ===== rtl/ebse_btn_lane.sv =====
module ebse_btn_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               scan_en,
  input  logic               down,
  input  ebse_pkg::cfg_t     cfg,
  output ebse_pkg::lane_evt_t evt
);

  logic                       was_r, was_nxt;
  logic                       seen_r, seen_nxt;
  logic [ebse_pkg::CNT_W-1:0] hold_r, hold_nxt;
  logic [ebse_pkg::CNT_W-1:0] h;

  always_comb begin
    was_nxt    = down;
    seen_nxt   = seen_r;
    hold_nxt   = hold_r;
    h          = hold_r;
    evt.hit    = 1'b0;
    evt.kind   = ebse_pkg::EVT_SHORT;
    evt.amount = '0;
    if (down && !was_r) begin
      hold_nxt = 8'd1;
      seen_nxt = 1'b0;
    end else if (down) begin
      // long press fires and restarts the hold count
      if (hold_r > cfg.long_press_scans) begin
        h        = 8'd1;
        seen_nxt = 1'b1;
        evt.hit  = 1'b1;
        evt.kind = ebse_pkg::EVT_LONG;
      end
      if (h != '0 && h != ebse_pkg::HOLD_TOP) begin
        hold_nxt = h + 8'd1;
      end else begin
        hold_nxt = h;
      end
    end else if (was_r) begin
      evt.hit  = !seen_r;
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_r  <= 1'b0;
      seen_r <= 1'b0;
      hold_r <= '0;
    end else if (scan_en) begin
      was_r  <= was_nxt;
      seen_r <= seen_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

// ===== rtl/ebse_merge.sv =====
module ebse_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  ebse_pkg::lane_evt_t          lane_evt [ebse_pkg::NUM_LANES],
  output logic                         idle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ebse_pkg::KIND_W-1:0]  out_kind,
  output logic [ebse_pkg::SRC_W-1:0]   out_src,
  output logic [ebse_pkg::AMT_W-1:0]   out_amount,
  output logic                         out_last
);

  localparam int NL = ebse_pkg::NUM_LANES;
  localparam int LW = ebse_pkg::LANE_W;

  logic [NL-1:0]               pend_r, pend_nxt;
  ebse_pkg::lane_evt_t         evt_r [NL];
  logic                        vld_r, vld_nxt;
  logic [ebse_pkg::KIND_W-1:0] kind_r;
  logic [ebse_pkg::SRC_W-1:0]  src_r;
  logic [ebse_pkg::AMT_W-1:0]  amt_r;
  logic                        last_r;

  logic [LW-1:0] pick;
  logic [LW-1:0] bidx;
  logic [NL-1:0] pick_mask;
  logic [NL-1:0] hits;
  logic          move;

  always_comb begin
    pick = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (pend_r[i]) pick = LW'(i);
    end
    for (int i = 0; i < NL; i++) begin
      hits[i] = lane_evt[i].hit;
    end
    pick_mask = NL'(1) << pick;
    bidx      = pick - LW'(ebse_pkg::NUM_ENCODERS);
    move      = (pend_r != '0) && (!vld_r || out_ready);
    pend_nxt  = pend_r;
    vld_nxt   = vld_r;
    if (load) begin
      pend_nxt = hits;
    end else if (move) begin
      pend_nxt = pend_r & ~pick_mask;
    end
    if (move) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NL; i++) begin
        evt_r[i] <= lane_evt[i];
      end
    end
    if (move) begin
      kind_r <= evt_r[pick].kind;
      src_r  <= (pick < LW'(ebse_pkg::NUM_ENCODERS)) ?
                ebse_pkg::SRC_W'(pick) : ebse_pkg::SRC_W'(bidx);
      amt_r  <= evt_r[pick].amount;
      last_r <= (pend_r & ~pick_mask) == '0;
    end
  end

  assign idle       = (pend_r == '0);
  assign out_valid  = vld_r;
  assign out_kind   = kind_r;
  assign out_src    = src_r;
  assign out_amount = amt_r;
  assign out_last   = last_r;

  a_stall_holds_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0 && vld_r && !out_ready) |=> $stable(pend_r))
    else $error("pending events changed while output stalled");

  a_move_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("event handoff did not retire exactly one lane");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (move && ((pend_r & ~pick_mask) == '0)) |=> (pend_r == '0 && last_r))
    else $error("last event sent with lanes still pending");

endmodule

// ===== rtl/encoder_button_scan_events.sv =====
// Channel  Dir  Handshake             Payload (lowest bit first)
// in_      in   in_tvalid/in_tready   in_tdata: scan_bits[15:0]
// out_     out  out_tvalid/out_tready out_tdata: event_kind[1:0], source_index[4:2],
//                                     turn_amount[9:5], zero[15:10]; out_tlast: last_event
// cfg_     in   cfg_we                cfg_index, cfg_wdata
//
// A scan is taken when in_tvalid and in_tready are both high; all eleven lanes update
// their state at that edge. The merge stage then hands the scan's events, one event a
// cycle while out_tready does not stall it, to its output register, and the next scan
// is taken once the last event of the current one has entered that register.
// Reset (rst_n low, synchronous) restores all lane state and the registers' defaults.
// A stalled out_tready holds the output register and the pending events.
module encoder_button_scan_events (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ebse_pkg::SCAN_W-1:0]        in_tdata,   // scan_bits[15:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ebse_pkg::OUT_W-1:0]         out_tdata,  // kind, source, amount, pad
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [ebse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ebse_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  ebse_pkg::cfg_t      cfg_r;
  logic [1:0]          phase_r;
  logic                scan_en;
  logic                idle;
  ebse_pkg::lane_evt_t lane_evt [ebse_pkg::NUM_LANES];

  logic [ebse_pkg::KIND_W-1:0] o_kind;
  logic [ebse_pkg::SRC_W-1:0]  o_src;
  logic [ebse_pkg::AMT_W-1:0]  o_amt;

  // Accept a scan only when no events of the previous one remain pending
  assign in_tready = idle;
  assign scan_en   = in_tvalid && in_tready;

  // Configuration: write by index, drop unknown codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_step       <= 4'd3;
      cfg_r.speed_limit      <= 4'd10;
      cfg_r.lockout_scans    <= 8'd60;
      cfg_r.long_press_scans <= 8'd200;
    end else if (cfg_we) begin
      unique case (ebse_pkg::cfg_reg_t'(cfg_index))
        ebse_pkg::REG_SPEED_STEP:  cfg_r.speed_step       <= cfg_wdata[3:0];
        ebse_pkg::REG_SPEED_LIMIT: cfg_r.speed_limit      <= cfg_wdata[3:0];
        ebse_pkg::REG_LOCKOUT:     cfg_r.lockout_scans    <= cfg_wdata;
        ebse_pkg::REG_LONG_PRESS:  cfg_r.long_press_scans <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scan phase: speed decays only on scans where it reads zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (scan_en) begin
      phase_r <= phase_r + 2'd1;
    end
  end

  // One lane per encoder: the input bits are active low, so low means asserted
  for (genvar k = 0; k < ebse_pkg::NUM_ENCODERS; k++) begin : g_enc
    ebse_enc_lane u_enc (
      .clk        (clk),
      .rst_n      (rst_n),
      .scan_en    (scan_en),
      .a_low      (!in_tdata[ebse_pkg::ENC_A_BIT[k]]),
      .b_low      (!in_tdata[ebse_pkg::ENC_B_BIT[k]]),
      .phase_zero (phase_r == 2'd0),
      .cfg        (cfg_r),
      .evt        (lane_evt[k])
    );
  end

  // One lane per button, placed after the encoders in event order
  for (genvar k = 0; k < ebse_pkg::NUM_BUTTONS; k++) begin : g_btn
    ebse_btn_lane u_btn (
      .clk     (clk),
      .rst_n   (rst_n),
      .scan_en (scan_en),
      .down    (!in_tdata[ebse_pkg::BTN_BIT[k]]),
      .cfg     (cfg_r),
      .evt     (lane_evt[ebse_pkg::NUM_ENCODERS + k])
    );
  end

  // Merge: capture lane hits, then advance them out lowest lane first
  ebse_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (scan_en),
    .lane_evt   (lane_evt),
    .idle       (idle),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_src    (o_src),
    .out_amount (o_amt),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, o_amt, o_src, o_kind};

endmodule
